/* hw/rtl/mpq_pkg.sv */
// shared types and constants of the multilevel priority ready queue
`default_nettype none

package mpq_pkg;

  // fixed field widths of the request and result items
  localparam int unsigned HandleW = 8;
  localparam int unsigned LevelW  = 4;

  // default sizing
  localparam int unsigned LevelsDef     = 16;
  localparam int unsigned LevelDepthDef = 16;
  localparam int unsigned HandleBitsDef = 8;

  // request kinds
  typedef enum logic {
    ReqEnqueue = 1'b0,
    ReqDequeue = 1'b1
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    StDone    = 2'd0,
    StEmpty   = 2'd1,
    StDropped = 2'd2
  } status_e;

endpackage

`default_nettype wire

/* hw/rtl/multilevel_priority_ready_queue.sv */
// top level of the multilevel priority ready queue
`default_nettype none

// Multilevel priority ready queue: LEVELS circular fifos of task handles, one per
// priority level, LEVEL_DEPTH entries each, all held in one shared handle ram.
// An enqueue item appends its handle to its level; a level already full, or a
// level number not below LEVELS, drops the item and answers status dropped. A
// dequeue item pops the oldest handle of the lowest-numbered non-empty level and
// returns it with that level, or answers status empty when no level holds any.
// Every request gives exactly one result item. A request is registered on
// acceptance in the request register and resolved there against the per-level
// head, tail and fill registers; when it moves on it issues the ram write or
// read, and its result is registered in the result register together with the
// ram read data. Throughput is one item per cycle while the result is not
// stalled; a stalled result holds the request register, which then stalls the
// input. Back-to-back requests are safe since a ram write always lands before
// any later read. Only the low HANDLE_BITS bits of a handle are kept (at most
// 8). The ram needs no clearing pass: the fill counts keep any unwritten entry
// from being read.
module multilevel_priority_ready_queue #(
  parameter int unsigned LEVELS      = mpq_pkg::LevelsDef,
  parameter int unsigned LEVEL_DEPTH = mpq_pkg::LevelDepthDef,
  parameter int unsigned HANDLE_BITS = mpq_pkg::HandleBitsDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // request channel
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire                                req_type_i,
  input  wire  [mpq_pkg::LevelW-1:0]         level_i,
  input  wire  [mpq_pkg::HandleW-1:0]        task_handle_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output mpq_pkg::status_e                   status_o,
  output logic [mpq_pkg::HandleW-1:0]        out_handle_o,
  output logic [mpq_pkg::LevelW-1:0]         out_level_o
);

  import mpq_pkg::*;

  // derived sizes
  localparam int unsigned StoreBits = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;
  localparam int unsigned LvlW      = $clog2(LEVELS);
  localparam int unsigned SlotW     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned FillW     = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned RamDepth  = LEVELS * LEVEL_DEPTH;
  localparam int unsigned AddrW     = $clog2(RamDepth);

  // request register
  logic                 s1_valid_q, s1_valid_d;
  req_e                 s1_req_q;
  logic [LevelW-1:0]    s1_level_q;
  logic [StoreBits-1:0] s1_handle_q;

  // per-level fifo bookkeeping
  logic [SlotW-1:0] head_q [LEVELS];
  logic [SlotW-1:0] tail_q [LEVELS];
  logic [FillW-1:0] fill_q [LEVELS];

  // handle ram
  logic [StoreBits-1:0] ram_q [RamDepth];
  logic [StoreBits-1:0] rd_q;

  // result register
  logic       out_valid_q;
  status_e    out_status_q;
  logic [LevelW-1:0] out_level_q;
  logic       out_hit_q;

  logic in_accept;
  logic s1_adv;

  // resolve logic
  logic            enq_lvl_ok;
  logic [LvlW-1:0] enq_lvl;
  logic            enq_full;
  logic            enq_do;
  logic [LEVELS-1:0] nonempty;
  logic            deq_found;
  logic [LvlW-1:0] deq_lvl;
  logic            deq_do;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  status_e         res_status;

  // handshake: the request register moves on whenever the result register is free
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // enqueue side: range check and full check on the named level
  assign enq_lvl_ok = 32'(s1_level_q) < LEVELS;
  assign enq_lvl    = LvlW'(s1_level_q);
  assign enq_full   = fill_q[enq_lvl] == FillW'(LEVEL_DEPTH);
  assign enq_do     = s1_adv && (s1_req_q == ReqEnqueue) && enq_lvl_ok && !enq_full;

  // dequeue side: lowest non-empty level wins
  always_comb begin
    deq_found = 1'b0;
    deq_lvl   = '0;
    for (int p = 0; p < LEVELS; p++) begin
      nonempty[p] = fill_q[p] != '0;
    end
    for (int p = LEVELS - 1; p >= 0; p--) begin
      if (nonempty[p]) begin
        deq_found = 1'b1;
        deq_lvl   = LvlW'(p);
      end
    end
  end

  assign deq_do = s1_adv && (s1_req_q == ReqDequeue) && deq_found;

  // flat ram address: level times depth plus slot
  assign wr_addr = AddrW'(AddrW'(enq_lvl) * AddrW'(LEVEL_DEPTH)) + AddrW'(tail_q[enq_lvl]);
  assign rd_addr = AddrW'(AddrW'(deq_lvl) * AddrW'(LEVEL_DEPTH)) + AddrW'(head_q[deq_lvl]);

  always_comb begin
    if (s1_req_q == ReqEnqueue) begin
      res_status = (enq_lvl_ok && !enq_full) ? StDone : StDropped;
    end else begin
      res_status = deq_found ? StDone : StEmpty;
    end
  end

  // slot advance with wrap at the level depth
  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(LEVEL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SlotW'(1);
    end
    return r;
  endfunction

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      fill_q      <= '{default: '0};
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (enq_do) begin
        tail_q[enq_lvl] <= next_slot(tail_q[enq_lvl]);
        fill_q[enq_lvl] <= fill_q[enq_lvl] + FillW'(1);
      end
      if (deq_do) begin
        head_q[deq_lvl] <= next_slot(head_q[deq_lvl]);
        fill_q[deq_lvl] <= fill_q[deq_lvl] - FillW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q    <= req_e'(req_type_i);
      s1_level_q  <= level_i;
      s1_handle_q <= task_handle_i[StoreBits-1:0];
    end
    if (s1_adv) begin
      out_status_q <= res_status;
      out_level_q  <= deq_do ? LevelW'(deq_lvl) : '0;
      out_hit_q    <= deq_do;
    end
  end

  // handle ram: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (enq_do) begin
      ram_q[wr_addr] <= s1_handle_q;
    end
    if (deq_do) begin
      rd_q <= ram_q[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_level_o  = out_level_q;
  assign out_handle_o = out_hit_q ? HandleW'(rd_q) : '0;

endmodule

`default_nettype wire

/* tb/multilevel_priority_ready_queue_tb.sv */
// self-checking testbench of the multilevel priority ready queue
`timescale 1ns / 1ps

module multilevel_priority_ready_queue_tb;
  import mpq_pkg::*;

  // sizing follows the block's defaults
  localparam int unsigned NUM_LEVELS  = LevelsDef;
  localparam int unsigned SLOTS       = LevelDepthDef;
  localparam int unsigned HANDLE_KEEP = HandleBitsDef;
  localparam logic [HandleW-1:0] HANDLE_MASK = (HandleW)'((64'd1 << HANDLE_KEEP) - 1);

  localparam int unsigned HOLD_CYCLES = 150;    // long receiver hold-off
  localparam int unsigned SETTLE      = 8;      // quiet time after the last result
  localparam int unsigned CYCLE_LIMIT = 400000; // far above the slowest legal run
  localparam int unsigned MAX_REPORTS = 10;

  // one expected result item
  typedef struct packed {
    status_e            st;
    logic [HandleW-1:0] hnd;
    logic [LevelW-1:0]  lvl;
  } sched_result_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                req_type_i    = ReqEnqueue;
  logic [LevelW-1:0]   level_i       = '0;
  logic [HandleW-1:0]  task_handle_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  status_e             status_o;
  logic [HandleW-1:0]  out_handle_o;
  logic [LevelW-1:0]   out_level_o;

  multilevel_priority_ready_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .level_i       (level_i),
    .task_handle_i (task_handle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_handle_o  (out_handle_o),
    .out_level_o   (out_level_o)
  );

  // predictor state: the per-level fifos as the block should hold them
  logic [HandleW-1:0] handle_ram [NUM_LEVELS][SLOTS];
  logic [3:0]         head_slot  [NUM_LEVELS];
  logic [3:0]         tail_slot  [NUM_LEVELS];
  logic [4:0]         fill_count [NUM_LEVELS];

  // results owed by the block, oldest first
  sched_result_t pending_results[$];

  // idling knobs, percent per cycle
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;

  logic        hold_active = 1'b0;
  event        hold_ev;

  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned enq_dropped   = 0;
  int unsigned deq_done      = 0;
  int unsigned deq_empty     = 0;
  int unsigned in_stall_hits = 0;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a solid stall while a hold-off runs
  always @(posedge clk_i) begin
    if (hold_active) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  // hold-off timer, counted here so the sender keeps running meanwhile
  initial begin
    int unsigned hold_cnt;
    forever begin
      @(hold_ev);
      hold_active <= 1'b1;
      for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  // count cycles in which the block pushed back on an offered item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o) in_stall_hits <= in_stall_hits + 1;
  end

  // first-in first-out priority queue behavior, one call per accepted request
  function automatic sched_result_t resolve_request(req_e kind, logic [LevelW-1:0] lvl,
                                                     logic [HandleW-1:0] hnd);
    sched_result_t res;
    bit            found;
    res.st  = StDone;
    res.hnd = '0;
    res.lvl = '0;
    found   = 1'b0;
    if (kind == ReqEnqueue) begin
      // full level, or a level number the block does not have, drops the item
      if (lvl >= NUM_LEVELS || fill_count[lvl] >= SLOTS) begin
        res.st = StDropped;
      end else begin
        handle_ram[lvl][tail_slot[lvl]] = hnd & HANDLE_MASK;
        tail_slot[lvl]  = (tail_slot[lvl] == SLOTS - 1) ? '0 : tail_slot[lvl] + 1'b1;
        fill_count[lvl] = fill_count[lvl] + 1'b1;
      end
    end else begin
      // lowest-numbered non-empty level wins
      for (int p = 0; p < NUM_LEVELS && !found; p++) begin
        if (fill_count[p] != 0) begin
          res.hnd       = handle_ram[p][head_slot[p]];
          res.lvl       = p[LevelW-1:0];
          head_slot[p]  = (head_slot[p] == SLOTS - 1) ? '0 : head_slot[p] + 1'b1;
          fill_count[p] = fill_count[p] - 1'b1;
          found         = 1'b1;
        end
      end
      if (!found) res.st = StEmpty;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input sched_result_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s: expected status %s handle %02h level %0d",
               $time, what, want.st.name(), want.hnd, want.lvl);
      $display("    got status %s handle %02h level %0d",
               status_o.name(), out_handle_o, out_level_o);
    end
  endtask

  // checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        want = '0;
        note_mismatch("result with nothing outstanding", want);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.st || out_handle_o !== want.hnd || out_level_o !== want.lvl) begin
          note_mismatch("result mismatch", want);
        end
        case (want.st)
          StDropped: enq_dropped++;
          StEmpty:   deq_empty++;
          default:   ;
        endcase
      end
    end
  end

  // one request item: optional idle cycles, then offer until accepted
  task automatic send_request(input req_e kind, input logic [LevelW-1:0] lvl,
                              input logic [HandleW-1:0] hnd);
    sched_result_t want;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    level_i       <= lvl;
    task_handle_i <= hnd;
    do @(posedge clk_i); while (in_stall_o);
    // accepted at this edge: predict now, in acceptance order
    want = resolve_request(kind, lvl, hnd);
    if (kind == ReqDequeue && want.st == StDone) deq_done++;
    pending_results.push_back(want);
    items_sent++;
  endtask

  // sender goes quiet until the block owes nothing
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned snd_pct, input int unsigned rcv_pct);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
  endtask

  // empty queue, both extreme levels and handles, priority order, a full level
  task automatic test_directed();
    int unsigned i;
    send_request(ReqDequeue, 4'd0, 8'h00);       // every level empty
    send_request(ReqEnqueue, 4'd15, 8'hFF);
    send_request(ReqEnqueue, 4'd0, 8'h00);
    send_request(ReqEnqueue, 4'd7, 8'hA5);
    send_request(ReqDequeue, 4'd15, 8'hFF);      // level 0 first, fields ignored
    send_request(ReqDequeue, 4'd3, 8'h5A);
    send_request(ReqDequeue, 4'd0, 8'h00);       // level 15 last
    send_request(ReqDequeue, 4'd9, 8'h33);       // empty again
    for (i = 0; i < SLOTS; i++) begin
      send_request(ReqEnqueue, 4'd9, 8'h10 + i[7:0]);
    end
    send_request(ReqEnqueue, 4'd9, 8'hEE);       // level 9 full: dropped
  endtask

  // random traffic; alternating fill-heavy and drain-heavy bursts with a hot
  // set of levels so levels fill up, drain, and wrap their slot pointers
  task automatic test_random_traffic(input int unsigned count);
    int unsigned n;
    int unsigned enq_pct;
    int unsigned hot_base;
    req_e        kind;
    logic [3:0]  lvl;
    enq_pct  = 75;
    hot_base = $urandom_range(0, 13);
    for (n = 0; n < count; n++) begin
      if (n % 40 == 39) begin
        enq_pct  = (enq_pct > 50) ? 30 : 75;
        hot_base = $urandom_range(0, 13);
      end
      kind = ($urandom_range(0, 99) < enq_pct) ? ReqEnqueue : ReqDequeue;
      if ($urandom_range(0, 1) != 0) lvl = 4'(hot_base + $urandom_range(0, 2));
      else                          lvl = 4'($urandom_range(0, 15));
      send_request(kind, lvl, 8'($urandom_range(0, 255)));
    end
  endtask

  // receiver holds off while the sender keeps offering: the block must fill,
  // raise its input stall and lose nothing
  task automatic test_output_holdoff();
    int unsigned n;
    set_idling(0, 0);
    ->hold_ev;
    for (n = 0; n < 48; n++) begin
      send_request(($urandom_range(0, 99) < 70) ? ReqEnqueue : ReqDequeue,
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    foreach (head_slot[l]) begin
      head_slot[l]  = '0;
      tail_slot[l]  = '0;
      fill_count[l] = '0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_directed();
    wait_all_results();

    // idling phases: none, sender, receiver, both lightly
    set_idling(0, 0);
    test_random_traffic(370);
    wait_all_results();
    set_idling(57, 0);
    test_random_traffic(370);
    wait_all_results();
    set_idling(0, 57);
    test_random_traffic(370);
    test_output_holdoff();
    wait_all_results();
    set_idling(12, 12);
    test_random_traffic(370);

    wait_all_results();
    repeat (SETTLE) @(posedge clk_i);

    $display("%0d requests: %0d enqueues kept, %0d dropped, %0d dequeues served, %0d empty",
             items_sent, items_sent - enq_dropped - deq_done - deq_empty, enq_dropped,
             deq_done, deq_empty);
    $display("idle/stall phases plus a %0d-cycle output hold-off (%0d input stall cycles)",
             HOLD_CYCLES, in_stall_hits);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
